FILE: design/adpcm4_audio_decoder_defines.svh
`ifndef ADPCM4_AUDIO_DECODER_DEFINES_SVH
`define ADPCM4_AUDIO_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define A4D_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define A4D_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/a4d_pkg.sv
package a4d_pkg;

    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int SAMPLE_W = 8;
    localparam int VOL_W    = 5;
    localparam int WORD_W   = 32;
    localparam int MUL_B_W  = 9;

    localparam logic [WORD_W-1:0] START_STEP = 32'h0000_0800;
    localparam logic [WORD_W-1:0] STEP_ROUND = 32'd127;
    localparam logic [VOL_W-1:0]  VOL_RESET  = 5'd16;
    localparam logic [VOL_W-1:0]  VOL_FULL   = 5'd16;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    // step multiplier, indexed by the raw nibble
    function automatic logic [7:0] adapt_lookup(input logic [NIB_W-1:0] nib);
        logic [7:0] f;
        unique case (nib)
            4'h0:                      f = 8'd112;
            4'h1, 4'h2, 4'h3, 4'h4:    f = 8'd128;
            4'h5, 4'h6:                f = 8'd136;
            4'h7, 4'h8, 4'h9:          f = 8'd192;
            4'hA, 4'hB:                f = 8'd136;
            default:                   f = 8'd128;
        endcase
        return f;
    endfunction

endpackage

FILE: design/a4d_if.sv
interface a4d_in_if;
    import a4d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface a4d_out_if;
    import a4d_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: design/adpcm4_audio_decoder.sv
// channel    dir   payload                      handshake
// in_chan    in    data_byte[7:0], restart      valid/ready
// out_chan   out   sample[7:0] signed, last     valid/ready
// cfg        in    cfg_wr_data[4:0]             cfg_wr_en, no ready
//
// a byte is accepted in idle, then each nibble steps through SM1, SM2, VOL, DIF,
// MUL, OUT, ADP and STP on the shared add/sub/multiply unit, stepped by the sequencer
// a nibble waits in its output step while the previous sample is not taken
// the next byte is accepted while the last sample still waits in the output register
// reset loads the start state and sets the volume to 16
`include "adpcm4_audio_decoder_defines.svh"

module adpcm4_audio_decoder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [a4d_pkg::VOL_W-1:0] cfg_wr_data,
    a4d_in_if.sink                 in_chan,
    a4d_out_if.source              out_chan
);
    import a4d_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM1,
        ST_SM2,
        ST_VOL,
        ST_DIF,
        ST_MUL,
        ST_OUT,
        ST_ADP,
        ST_STP
    } state_t;

    state_t                state_reg;
    logic                  nib_sel_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic [WORD_W-1:0]     po_reg;
    logic [WORD_W-1:0]     ppo_reg;
    logic [WORD_W-1:0]     sm_reg;
    logic [WORD_W-1:0]     step_reg;
    logic [WORD_W-1:0]     t_reg;
    logic [WORD_W-1:0]     u_reg;
    logic [VOL_W-1:0]      vol_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_sample_reg;
    logic                  out_last_reg;

    logic [NIB_W-1:0]      nib;
    logic [SAMPLE_W-1:0]   clamp;
    logic                  in_fire;
    logic                  out_free;

    alu_op_t               alu_op;
    logic [WORD_W-1:0]     alu_a;
    logic [WORD_W-1:0]     alu_b;
    logic [WORD_W-1:0]     alu_sum;
    logic signed [WORD_W+MUL_B_W-1:0] mul_full;
    logic [WORD_W-1:0]     alu_res;

    assign in_fire  = in_chan.valid && in_chan.ready;
    assign out_free = !out_valid_reg || out_chan.ready;
    assign nib      = nib_sel_reg ? byte_reg[BYTE_W-1:NIB_W] : byte_reg[NIB_W-1:0];

    // sm >>> 8 saturated to 8 bits
    always_comb
    begin
        if ((&sm_reg[WORD_W-1:15]) || !(|sm_reg[WORD_W-1:15]))
        begin
            clamp = sm_reg[15:8];
        end
        else if (sm_reg[WORD_W-1])
        begin
            clamp = 8'h80;
        end
        else
        begin
            clamp = 8'h7F;
        end
    end

    // operand select for the shared unit
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_SM1:
            begin
                alu_op = ALU_SUB;
                alu_a  = sm_reg;
                alu_b  = WORD_W'($signed(sm_reg) >>> 3);
            end
            ST_SM2:
            begin
                alu_a = t_reg;
                alu_b = ppo_reg;
            end
            ST_VOL:
            begin
                alu_op = ALU_MUL;
                alu_a  = {{(WORD_W-SAMPLE_W){clamp[SAMPLE_W-1]}}, clamp};
                alu_b  = {{(WORD_W-VOL_W){1'b0}}, vol_reg};
            end
            ST_DIF:
            begin
                alu_op = ALU_SUB;
                alu_a  = po_reg;
                alu_b  = ppo_reg;
            end
            ST_MUL:
            begin
                alu_op = ALU_MUL;
                alu_a  = step_reg;
                alu_b  = {{(WORD_W-NIB_W){nib[NIB_W-1]}}, nib};
            end
            ST_OUT:
            begin
                alu_a = t_reg;
                alu_b = u_reg;
            end
            ST_ADP:
            begin
                alu_op = ALU_MUL;
                alu_a  = step_reg;
                alu_b  = {{(WORD_W-8){1'b0}}, adapt_lookup(nib)};
            end
            ST_STP:
            begin
                alu_a = t_reg;
                alu_b = STEP_ROUND;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // shared adder and multiplier, low word kept
    always_comb
    begin
        if (alu_op == ALU_SUB)
        begin
            alu_sum = alu_a - alu_b;
        end
        else
        begin
            alu_sum = alu_a + alu_b;
        end
        mul_full = $signed(alu_a) * $signed(alu_b[MUL_B_W-1:0]);
        if (alu_op == ALU_MUL)
        begin
            alu_res = mul_full[WORD_W-1:0];
        end
        else
        begin
            alu_res = alu_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nib_sel_reg   <= 1'b0;
            po_reg        <= '0;
            ppo_reg       <= '0;
            sm_reg        <= '0;
            step_reg      <= START_STEP;
            vol_reg       <= VOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vol_reg <= cfg_wr_data;
            end
            // in the output step the register is reloaded instead
            if (out_valid_reg && out_chan.ready && (state_reg != ST_VOL))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        byte_reg    <= in_chan.data_byte;
                        nib_sel_reg <= 1'b0;
                        if (in_chan.restart)
                        begin
                            po_reg   <= '0;
                            ppo_reg  <= '0;
                            sm_reg   <= '0;
                            step_reg <= START_STEP;
                        end
                        state_reg <= ST_SM1;
                    end
                end
                ST_SM1:
                begin
                    t_reg     <= alu_res;
                    state_reg <= ST_SM2;
                end
                ST_SM2:
                begin
                    sm_reg    <= alu_res;
                    state_reg <= ST_VOL;
                end
                ST_VOL:
                begin
                    if (out_free)
                    begin
                        if (vol_reg < VOL_FULL)
                        begin
                            out_sample_reg <= alu_res[SAMPLE_W+3:4];
                        end
                        else
                        begin
                            out_sample_reg <= clamp;
                        end
                        out_last_reg  <= nib_sel_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_DIF;
                    end
                end
                ST_DIF:
                begin
                    u_reg     <= alu_res;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    t_reg     <= alu_res;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    ppo_reg   <= po_reg;
                    po_reg    <= alu_res;
                    state_reg <= ST_ADP;
                end
                ST_ADP:
                begin
                    t_reg     <= alu_res;
                    state_reg <= ST_STP;
                end
                ST_STP:
                begin
                    step_reg <= WORD_W'($signed(alu_res) >>> 7);
                    if (nib_sel_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        nib_sel_reg <= 1'b1;
                        state_reg   <= ST_SM1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_chan.ready   = (state_reg == ST_IDLE);
    assign out_chan.valid  = out_valid_reg;
    assign out_chan.sample = out_sample_reg;
    assign out_chan.last   = out_last_reg;

    `A4D_ASSERT_NEXT(a_accept_starts, in_fire, (state_reg == ST_SM1) && !nib_sel_reg, "request accepted but decode did not start")
    `A4D_ASSERT_NEXT(a_sample_loaded, (state_reg == ST_VOL) && out_free, out_chan.valid && (out_chan.last == $past(nib_sel_reg)), "sample not loaded with the right nibble flag")
    `A4D_ASSERT_NEXT(a_step_hold, (state_reg != ST_STP) && !in_fire, $stable(step_reg), "step size changed outside its update")
    `A4D_ASSERT_SAME(a_busy_not_ready, state_reg != ST_IDLE, !in_chan.ready, "ready raised during decode")

endmodule

FILE: sim/a4d_checker.sv
`timescale 1ns / 100ps

module a4d_checker
    import a4d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [VOL_W-1:0] cfg_wr_data,
    a4d_in_if                in_mon,
    a4d_out_if               out_mon,
    output int               error_count,
    output int               samples_due
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sample_t;

    sample_t           expected_samples[$];
    logic [WORD_W-1:0] last_out;
    logic [WORD_W-1:0] older_out;
    logic [WORD_W-1:0] smooth_acc;
    logic [WORD_W-1:0] step_q;
    logic [VOL_W-1:0]  gain;

    // step growth factor, indexed by code + 8
    function automatic logic [7:0] adapt_factor(input logic [NIB_W-1:0] idx);
        logic [7:0] f;
        case (idx)
            4'd0, 4'd1, 4'd15:  f = 8'd192;
            4'd2, 4'd3, 4'd13,
            4'd14:              f = 8'd136;
            4'd8:               f = 8'd112;
            default:            f = 8'd128;
        endcase
        return f;
    endfunction

    task automatic reload_predictor();
        last_out   = '0;
        older_out  = '0;
        smooth_acc = '0;
        step_q     = START_STEP;
    endtask

    task automatic decode_code(input logic [NIB_W-1:0] nib,
                               output logic signed [SAMPLE_W-1:0] smp);
        logic [WORD_W-1:0] code;
        logic [WORD_W-1:0] next_out;
        logic [WORD_W-1:0] scaled_step;
        logic [WORD_W-1:0] leak;
        int                level;
        leak = $signed(smooth_acc) >>> 3;
        smooth_acc = older_out + smooth_acc - leak;
        level = $signed(smooth_acc) >>> 8;
        if (level < -128)
            level = -128;
        else if (level > 127)
            level = 127;
        code = {{(WORD_W-NIB_W){nib[NIB_W-1]}}, nib};
        next_out = code * step_q + last_out - older_out;
        older_out = last_out;
        last_out = next_out;
        scaled_step = step_q * adapt_factor(nib ^ 4'h8) + STEP_ROUND;
        step_q = $signed(scaled_step) >>> 7;
        if (gain < VOL_FULL)
            level = (level * int'(gain)) >>> 4;
        smp = level[SAMPLE_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [SAMPLE_W-1:0] lo_smp;
        logic signed [SAMPLE_W-1:0] hi_smp;
        sample_t                    want;
        if (!rst_n)
        begin
            reload_predictor();
            gain = VOL_RESET;
            expected_samples.delete();
        end
        else
        begin
            if (cfg_wr_en)
                gain = cfg_wr_data;
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.restart)
                    reload_predictor();
                decode_code(in_mon.data_byte[3:0], lo_smp);
                expected_samples.push_back('{sample: lo_smp, last: 1'b0});
                decode_code(in_mon.data_byte[7:4], hi_smp);
                expected_samples.push_back('{sample: hi_smp, last: 1'b1});
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected sample %0d last %0b", $time,
                             out_mon.sample, out_mon.last);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (out_mon.sample !== want.sample)
                    begin
                        error_count++;
                        $display("%0t: sample mismatch, expected %0d, got %0d", $time,
                                 want.sample, out_mon.sample);
                    end
                    if (out_mon.last !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last mismatch, expected %0b, got %0b", $time,
                                 want.last, out_mon.last);
                    end
                end
            end
        end
        samples_due = expected_samples.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import a4d_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 300;
    localparam int PHASE_ITEMS = 124;
    localparam int PHASES      = 7;
    localparam int STEEP_RUN   = 20;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [VOL_W-1:0] cfg_wr_data;
    int               error_count;
    int               samples_due;
    int               cycle_count = 0;
    int               hold_off_cycles = 0;
    bit               source_eager = 1'b0;
    bit               sink_eager = 1'b0;

    a4d_in_if  in_chan();
    a4d_out_if out_chan();

    adpcm4_audio_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_chan     (in_chan),
        .out_chan    (out_chan)
    );

    a4d_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_mon      (in_chan),
        .out_mon     (out_chan),
        .error_count (error_count),
        .samples_due (samples_due)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic r);
        int gap;
        gap = source_eager ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_chan.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_chan.valid     = 1'b1;
        in_chan.data_byte = b;
        in_chan.restart   = r;
        do @(posedge clk); while (!in_chan.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_chan.valid = 1'b0;
        wait (samples_due == 0);
        @(negedge clk);
    endtask

    task automatic write_volume(input logic [VOL_W-1:0] v);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [NIB_W-1:0] extreme_code();
        logic [NIB_W-1:0] c;
        case ($urandom_range(0, 4))
            0:       c = 4'h0;
            1:       c = 4'h7;
            2:       c = 4'h8;
            3:       c = 4'h9;
            default: c = 4'hF;
        endcase
        return c;
    endfunction

    function automatic logic [NIB_W-1:0] steep_code();
        return ($urandom_range(0, 1) == 1) ? 4'h7 : 4'h8;
    endfunction

    // sample sink
    initial
    begin : sink
        int gap;
        int stall;
        out_chan.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
                out_chan.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            gap = sink_eager ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_chan.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_chan.ready = 1'b1;
            do @(posedge clk); while (!out_chan.valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [BYTE_W-1:0] lead_bytes [7];
        logic              lead_restart [7];
        logic [VOL_W-1:0]  vol_plan [PHASES];
        logic [VOL_W-1:0]  v;
        logic [BYTE_W-1:0] b;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        in_chan.valid     = 1'b0;
        in_chan.data_byte = '0;
        in_chan.restart   = 1'b0;
        lead_bytes   = '{8'h00, 8'hFF, 8'h77, 8'h88, 8'h08, 8'hF0, 8'h5A};
        lead_restart = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        vol_plan     = '{5'd0, 5'd15, 5'd31, 5'd1, 5'd17, 5'd16, 5'd8};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // full volume from reset, extreme codes, restart mid-stream
        for (int i = 0; i < 7; i++)
            send_byte(lead_bytes[i], lead_restart[i]);
        // steepest codes until the step size wraps
        for (int i = 0; i < 18; i++)
            send_byte(8'h87, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            v = (p == PHASES - 1) ? VOL_W'($urandom_range(0, 31)) : vol_plan[p];
            write_volume(v);
            if (p == 1)
                hold_off_cycles = LONG_STALL;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 48 == 0)
                begin
                    source_eager = ($urandom_range(0, 3) == 0);
                    sink_eager   = ($urandom_range(0, 3) == 0);
                end
                if (p == 3 && i == 70)
                    wait_drained();
                if (i == 20)
                begin
                    send_byte(8'h00, 1'b1);
                    for (int k = 0; k < STEEP_RUN; k++)
                        send_byte({steep_code(), steep_code()}, 1'b0);
                end
                if ($urandom_range(0, 9) < 7)
                    b = BYTE_W'($urandom_range(0, 255));
                else
                    b = {extreme_code(), extreme_code()};
                send_byte(b, $urandom_range(0, 39) == 0);
            end
        end

        wait_drained();
        repeat (40) @(negedge clk);
        if (error_count == 0 && samples_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/a4d_pkg.sv
design/a4d_if.sv
design/adpcm4_audio_decoder.sv
sim/a4d_checker.sv
sim/testbench.sv
